// File: rtl/core/http_request_completeness_framer_top_macros.svh
// Assertion macros used by the framer's checker.
`ifndef HTTP_REQUEST_COMPLETENESS_FRAMER_TOP_MACROS_SVH
`define HTTP_REQUEST_COMPLETENESS_FRAMER_TOP_MACROS_SVH

// Same-cycle implication, off while in reset.
`define HRCF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define HRCF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Check that holds in the cycle after a reset cycle.
`define HRCF_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hrcf_pkg.sv
// Shared types and constants of the request completeness framer.
package hrcf_pkg;

  localparam int LENGTH_BITS = 32;
  localparam logic [63:0] LEN_MASK = 64'((65'd1 << LENGTH_BITS) - 65'd1);

  localparam int DATA_W = 8;
  localparam int LIM_W = 32;
  localparam int LV_W = LIM_W + 1;
  localparam int ACC_W = LV_W + 4;
  localparam int BC_W = 33;
  localparam int STATUS_W = 2;

  localparam int TAG_LEN = 15;
  localparam int HIT_W = 16;
  localparam int TAG_W = 4;
  localparam int TM_W = 3;
  localparam logic [TM_W-1:0] TERM_LEN = 3'd4;

  localparam logic [DATA_W-1:0] TAG_TEXT [TAG_LEN] = '{
    "C", "o", "n", "t", "e", "n", "t", "-", "L", "e", "n", "g", "t", "h", ":"
  };
  localparam logic [DATA_W-1:0] CHAR_CR = 8'h0D;
  localparam logic [DATA_W-1:0] CHAR_LF = 8'h0A;
  localparam logic [DATA_W-1:0] CHAR_C = "C";
  localparam logic [DATA_W-1:0] CHAR_ZERO = "0";
  localparam logic [DATA_W-1:0] CHAR_NINE = "9";

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_LEN = 2'd2;

  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_BODY = 1'b0;
  localparam logic [LIM_W-1:0] MAX_BODY_RESET = 32'd1048576;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // One classified request byte.
  typedef struct packed {
    logic              starts;
    logic              is_digit;
    logic [3:0]        digit;
    logic [HIT_W-1:0]  tag_hit;
    logic              is_c;
    logic              is_cr;
    logic              is_lf;
  } hrcf_class_t;

endpackage

// File: rtl/core/hrcf_req_if.sv
// Request channel: one byte of the request stream per transfer.
interface hrcf_req_if;
  import hrcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              starts_request;

  modport source (output valid, output data_byte, output starts_request, input ready);
  modport sink (input valid, input data_byte, input starts_request, output ready);
endinterface

// File: rtl/core/hrcf_res_if.sv
// Result channel: completeness verdict per request byte.
interface hrcf_res_if;
  import hrcf_pkg::*;

  logic                valid;
  logic                ready;
  logic                complete;
  logic [STATUS_W-1:0] status;
  logic [LIM_W-1:0]    content_length;

  modport source (output valid, output complete, output status, output content_length,
                  input ready);
  modport sink (input valid, input complete, input status, input content_length,
                output ready);
endinterface

// File: rtl/core/hrcf_front.sv
// Front end: accept request bytes and classify them for the parser.
module hrcf_front (
  hrcf_req_if.sink            req,
  input  logic                q_full,
  output logic                push,
  output hrcf_pkg::hrcf_class_t item
);
  import hrcf_pkg::*;

  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] b_off;

  assign b = req.data_byte;
  assign b_off = b - CHAR_ZERO;
  assign req.ready = !q_full;
  assign push = req.valid && !q_full;

  always_comb begin
    item = '0;
    item.starts = req.starts_request;
    item.is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    item.digit = b_off[3:0];
    // Match against every tag position at once; the parser picks by progress.
    for (int k = 0; k < TAG_LEN; k++) begin
      item.tag_hit[k] = (b == TAG_TEXT[k]);
    end
    item.is_c = (b == CHAR_C);
    item.is_cr = (b == CHAR_CR);
    item.is_lf = (b == CHAR_LF);
  end
endmodule

// File: rtl/core/hrcf_queue.sv
// Small FIFO between the classifier and the parser.
module hrcf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hrcf_pkg::hrcf_class_t wr_item,
  output logic                  full,
  output logic                  not_empty,
  output hrcf_pkg::hrcf_class_t rd_item,
  input  logic                  pop
);
  import hrcf_pkg::*;

  hrcf_class_t         mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

// File: rtl/core/hrcf_back.sv
// Back end: per-byte header parse, length decode, body count and result register.
module hrcf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [hrcf_pkg::LIM_W-1:0] body_limit,
  input  logic                    q_valid,
  input  hrcf_pkg::hrcf_class_t   item,
  output logic                    pop,
  hrcf_res_if.source              res
);
  import hrcf_pkg::*;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  phase_t              phase, phase_next, cur_phase;
  logic [TM_W-1:0]     tm, tm_next, cur_tm;
  logic [TAG_W-1:0]    tag, tag_next, cur_tag;
  logic [LV_W-1:0]     lv, lv_next, cur_lv;
  logic                hdone, hdone_next, cur_hdone;
  logic [BC_W-1:0]     bc, bc_next, cur_bc;
  logic [STATUS_W-1:0] err, err_next, cur_err;

  logic                out_valid;
  logic                out_complete, complete_next;
  logic [STATUS_W-1:0] out_status;
  logic [LIM_W-1:0]    out_len, len_next;

  logic [LIM_W-1:0]    lim;
  logic [LV_W-1:0]     lim_ext;
  logic [LV_W-1:0]     lim_p1;
  logic [ACC_W-1:0]    acc;
  logic                term_hit;

  assign pop = q_valid && (!out_valid || res.ready);

  assign res.valid = out_valid;
  assign res.complete = out_complete;
  assign res.status = out_status;
  assign res.content_length = out_len;

  always_comb begin
    lim = ({32'b0, body_limit} < LEN_MASK) ? body_limit : LEN_MASK[LIM_W-1:0];
    lim_ext = {1'b0, lim};
    lim_p1 = lim_ext + 1'b1;

    // A request start clears the parse state before its byte is taken.
    cur_phase = item.starts ? PH_SEARCH : phase;
    cur_tm = item.starts ? '0 : tm;
    cur_tag = item.starts ? '0 : tag;
    cur_lv = item.starts ? '0 : lv;
    cur_hdone = item.starts ? 1'b0 : hdone;
    cur_bc = item.starts ? '0 : bc;
    cur_err = item.starts ? ST_OK : err;

    phase_next = cur_phase;
    tm_next = cur_tm;
    tag_next = cur_tag;
    lv_next = cur_lv;
    hdone_next = cur_hdone;
    bc_next = cur_bc;
    err_next = cur_err;

    acc = {1'b0, cur_lv, 3'b000} + {3'b000, cur_lv, 1'b0} + {{(ACC_W-4){1'b0}}, item.digit};

    case (cur_tm)
      3'd0, 3'd2: term_hit = item.is_cr;
      3'd1, 3'd3: term_hit = item.is_lf;
      default: term_hit = 1'b0;
    endcase

    if (!cur_hdone) begin
      case (cur_phase)
        PH_SEARCH: begin
          if (item.tag_hit[cur_tag]) begin
            tag_next = cur_tag + 1'b1;
          end else begin
            tag_next = item.is_c ? TAG_W'(1) : '0;
          end
          if (tag_next == TAG_W'(TAG_LEN)) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (item.is_digit) begin
            lv_next = ({{(LV_W-4){1'b0}}, item.digit} > lim_ext) ? lim_p1
                      : {{(LV_W-4){1'b0}}, item.digit};
            phase_next = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (item.is_digit) begin
            // Saturate just above the limit.
            lv_next = (acc > {4'b0, lim_ext}) ? lim_p1 : acc[LV_W-1:0];
          end else if (cur_lv > lim_ext) begin
            err_next = ST_BAD_LEN;
            lv_next = '0;
            phase_next = PH_DONE;
          end else begin
            phase_next = PH_DONE;
          end
        end
        default: begin
          phase_next = cur_phase;
        end
      endcase

      if (term_hit) begin
        tm_next = cur_tm + 1'b1;
      end else begin
        tm_next = item.is_cr ? TM_W'(1) : '0;
      end
      if (tm_next == TERM_LEN) begin
        hdone_next = 1'b1;
        // Header ended while the value was still pending: invalid.
        if (phase_next == PH_SKIP || phase_next == PH_DIGITS) begin
          err_next = ST_BAD_LEN;
          lv_next = '0;
          phase_next = PH_DONE;
        end
      end
    end else begin
      if (cur_bc != '1) begin
        bc_next = cur_bc + 1'b1;
      end
      if (cur_err == ST_OK && cur_lv == '0) begin
        err_next = ST_NO_LEN;
      end
    end

    complete_next = hdone_next && (err_next == ST_OK) && ({1'b0, bc_next} >= {1'b0, lv_next});
    len_next = (err_next == ST_BAD_LEN || lv_next > lim_ext) ? '0 : lv_next[LIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SEARCH;
      tm <= '0;
      tag <= '0;
      lv <= '0;
      hdone <= 1'b0;
      bc <= '0;
      err <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase <= phase_next;
        tm <= tm_next;
        tag <= tag_next;
        lv <= lv_next;
        hdone <= hdone_next;
        bc <= bc_next;
        err <= err_next;
        out_valid <= 1'b1;
        out_complete <= complete_next;
        out_status <= err_next;
        out_len <= len_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/core/http_request_completeness_framer_top.sv
// Top level of the HTTP request completeness framer.
//
// Feed the request stream one byte per transfer on req; every accepted byte
// yields exactly one result on res: complete (header ended with CR LF CR LF,
// no error, and the body count reached Content-Length), status (0 ok or
// pending, 1 invalid length, 2 body without length) and the decoded length.
// Set starts_request on the first byte of each new request to clear the
// parse state. Throughput is one byte per clock unless res.ready stalls: the
// front end classifies a byte in the cycle it is accepted and pushes it into
// a four-entry queue, and the back end retires one byte per cycle while its
// output register is free or being taken, the whole per-byte state update
// (tag and terminator match, multiply-by-ten accumulate, limit compare, body
// count) being combinational. A result is registered after its byte leaves the
// queue, which takes bytes while a result awaits res.ready until it is full.
// Write the body size limit (byte address 0, reset 1048576) over APB only
// while the block is idle.
module http_request_completeness_framer_top (
  input  logic                           clk,
  input  logic                           rst,
  hrcf_req_if.sink                       req,
  hrcf_res_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hrcf_pkg::ADDR_W-1:0]     paddr,
  input  logic [hrcf_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hrcf_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hrcf_pkg::*;

  logic [LIM_W-1:0]     body_limit;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  hrcf_class_t          f_item;
  hrcf_class_t          q_item;
  logic                 f_push;
  logic                 q_full;
  logic                 q_valid;
  logic                 b_pop;

  // Register file: a single limit register, written in the APB access phase.
  assign pready = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (reg_idx == REG_MAX_BODY) ? body_limit : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      body_limit <= MAX_BODY_RESET;
    end else if (cfg_wr && reg_idx == REG_MAX_BODY) begin
      body_limit <= pwdata;
    end
  end

  // Classify each accepted byte.
  hrcf_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (f_push),
    .item   (f_item)
  );

  // Decouple acceptance from result back-pressure.
  hrcf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .wr_item   (f_item),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_item   (q_item),
    .pop       (b_pop)
  );

  // Advance the parse state and register one result per byte.
  hrcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .body_limit (body_limit),
    .q_valid    (q_valid),
    .item       (q_item),
    .pop        (b_pop),
    .res        (res)
  );
endmodule

// File: rtl/core/hrcf_checker.sv
// Port-level checks of the framer's result channel, bound to the top level.
`include "http_request_completeness_framer_top_macros.svh"

module hrcf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic                          res_complete,
  input logic [hrcf_pkg::STATUS_W-1:0] res_status,
  input logic [hrcf_pkg::LIM_W-1:0]    res_content_length
);
  import hrcf_pkg::*;

  `HRCF_ASSERT_IMP(a_complete_ok, res_valid && res_complete, res_status == ST_OK, "complete with error status")
  `HRCF_ASSERT_IMP(a_bad_len_zero, res_valid && res_status == ST_BAD_LEN, res_content_length == '0, "invalid length shown nonzero")
  `HRCF_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(res_complete) && $stable(res_status) && $stable(res_content_length), "stalled result changed")
  `HRCF_ASSERT_RST(a_rst_idle, !res_valid, "result valid after reset")
endmodule

bind http_request_completeness_framer_top hrcf_checker u_hrcf_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_complete       (res.complete),
  .res_status         (res.status),
  .res_content_length (res.content_length)
);

// File: bench/http_request_completeness_framer_top_tb.sv
// Self-checking bench for the HTTP request completeness framer: directed table, random requests.
`timescale 1ns / 100ps

module http_request_completeness_framer_top_tb;
  import hrcf_pkg::*;

  // Request bytes queued per configuration setting, one setting per phase.
  localparam int ITEMS_PER_PHASE = 170;
  localparam int NUM_CFG = 8;
  // Body count saturates at 2^33-1.
  localparam logic [63:0] BODY_SAT = 64'h1_FFFF_FFFF;
  localparam logic [8*TAG_LEN-1:0] LEN_TAG = "Content-Length:";
  localparam string BODY_POOL = "\r\nContent-Length:0123456789";

  typedef enum logic [1:0] {PH_TAG, PH_SKIP, PH_DIGITS, PH_DONE} len_phase_t;

  // One verdict on the result channel.
  typedef struct packed {
    logic                complete;
    logic [STATUS_W-1:0] status;
    logic [LIM_W-1:0]    content_length;
  } verdict_t;

  // One request byte to send; lit marks a row whose verdict is typed in by hand.
  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       lit;
    verdict_t   want;
  } stim_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  hrcf_req_if req ();
  hrcf_res_if res ();

  http_request_completeness_framer_top uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bytes waiting to be sent, and verdicts waiting for their result.
  stim_t    byte_q[$];
  verdict_t verdict_q[$];
  stim_t    cur_item;
  int       phase_items;
  int       mismatch_cnt = 0;
  int       result_idx = 0;
  logic [31:0] cfg_vals [NUM_CFG];

  // Predictor copy of the framer state and its one register.
  logic [31:0]         max_body = MAX_BODY_RESET;
  int                  term_cnt = 0;
  int                  tag_cnt = 0;
  len_phase_t          len_phase = PH_TAG;
  logic [63:0]         len_val = '0;
  logic                hdr_done = 1'b0;
  logic [63:0]         body_cnt = '0;
  logic [STATUS_W-1:0] err_code = ST_OK;

  // The length limit is the register clipped to what LENGTH_BITS can hold.
  function automatic logic [63:0] cur_limit();
    return ({32'd0, max_body} < LEN_MASK) ? {32'd0, max_body} : LEN_MASK;
  endfunction

  // Advance the framer state by one byte and return the verdict it yields.
  function automatic verdict_t track_byte(input logic [7:0] b, input logic st);
    logic [63:0] lim;
    logic [63:0] acc;
    logic        is_dig;
    logic [7:0]  term_byte;
    verdict_t    v;
    lim = cur_limit();
    is_dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    // A new request wipes every bit of parse state first.
    if (st) begin
      term_cnt = 0;
      tag_cnt = 0;
      len_phase = PH_TAG;
      len_val = '0;
      hdr_done = 1'b0;
      body_cnt = '0;
      err_code = ST_OK;
    end
    if (!hdr_done) begin
      case (len_phase)
        PH_TAG: begin
          if (tag_cnt < TAG_LEN && b == LEN_TAG[8*(TAG_LEN-1-tag_cnt) +: 8]) tag_cnt++;
          else tag_cnt = (b == CHAR_C) ? 1 : 0;
          if (tag_cnt == TAG_LEN) len_phase = PH_SKIP;
        end
        PH_SKIP: begin
          if (is_dig) begin
            len_val = 64'(b - CHAR_ZERO);
            if (len_val > lim) len_val = lim + 1;
            len_phase = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            // Saturate one above the limit so an overflow stays visible.
            acc = len_val * 10 + 64'(b - CHAR_ZERO);
            len_val = (acc > lim) ? lim + 1 : acc;
          end else if (len_val > lim) begin
            err_code = ST_BAD_LEN;
            len_val = '0;
            len_phase = PH_DONE;
          end else begin
            len_phase = PH_DONE;
          end
        end
        default: ;
      endcase
      term_byte = term_cnt[0] ? CHAR_LF : CHAR_CR;
      if (term_cnt < 4 && b == term_byte) term_cnt++;
      else term_cnt = (b == CHAR_CR) ? 1 : 0;
      if (term_cnt == 4) begin
        hdr_done = 1'b1;
        // Header closed while a value was still expected or being read.
        if (len_phase == PH_SKIP || len_phase == PH_DIGITS) begin
          err_code = ST_BAD_LEN;
          len_val = '0;
          len_phase = PH_DONE;
        end
      end
    end else begin
      // Body bytes are only counted, never scanned.
      if (body_cnt < BODY_SAT) body_cnt++;
      if (err_code == ST_OK && len_val == 0) err_code = ST_NO_LEN;
    end
    v.content_length = (err_code == ST_BAD_LEN || len_val > lim) ? '0 : len_val[LIM_W-1:0];
    v.status = err_code;
    v.complete = hdr_done && err_code == ST_OK && body_cnt >= len_val;
    return v;
  endfunction

  task automatic push_item(input logic [7:0] b, input logic st, input logic lit,
                           input verdict_t want);
    stim_t it;
    it.b = b;
    it.st = st;
    it.lit = lit;
    it.want = want;
    byte_q.push_back(it);
    phase_items++;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic st);
    push_item(b, st, 1'b0, '0);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
  endtask

  function automatic string pick_chars(input string pool, input int n);
    string s;
    int    k;
    s = "";
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, pool.len() - 1);
      s = {s, pool.substr(k, k)};
    end
    return s;
  endfunction

  // Queue one random request: mostly well formed with random content, some noise.
  task automatic build_request();
    int          kind;
    int          pieces;
    int          tag_at;
    int          blen;
    logic        numeric;
    logic [63:0] lim;
    logic [63:0] val;
    string       digits;
    lim = cur_limit();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 24))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      return;
    end
    // Request line; now and then leave starts low so bytes run on into the old request.
    push_byte("G", $urandom_range(0, 19) != 0);
    push_text({pick_chars("ET /x", $urandom_range(0, 4)), "\r\n"});
    pieces = $urandom_range(0, 3);
    tag_at = (kind < 75) ? int'($urandom_range(0, pieces)) : -1;
    numeric = 1'b0;
    val = '0;
    for (int p = 0; p <= pieces; p++) begin
      if (p == tag_at) begin
        numeric = 1'b1;
        digits = "";
        case ($urandom_range(0, 11))
          0: numeric = 1'b0;
          1: val = lim;
          2: val = lim + 1;
          3: val = (lim != 0) ? lim - 1 : 64'd0;
          4: begin
            numeric = 1'b0;
            digits = pick_chars("0123456789", $urandom_range(11, 22));
          end
          default: val = 64'($urandom_range(0, 24));
        endcase
        if (numeric) digits = {pick_chars("0", $urandom_range(0, 2)), $sformatf("%0d", val)};
        // A stray C just ahead must restart the tag match, not spoil it.
        if ($urandom_range(0, 7) == 0) push_text("C");
        push_text("Content-Length:");
        push_text(pick_chars(" \t", $urandom_range(0, 2)));
        if ($urandom_range(0, 9) == 0) push_text(pick_chars("xX;", 1));
        push_text(digits);
        if ($urandom_range(0, 7) == 0) push_text(pick_chars(" ab", $urandom_range(1, 3)));
        push_text("\r\n");
      end else begin
        case ($urandom_range(0, 5))
          0, 1: push_text({pick_chars("Hosta-xyC", $urandom_range(1, 6)), ": ",
                           pick_chars("abc0C9 ", $urandom_range(0, 5)), "\r\n"});
          2: push_text({"content-length: ", $sformatf("%0d", $urandom_range(0, 9)), "\r\n"});
          3: push_text({"Content-Length", pick_chars(" C", 1), "5\r\n"});
          4: push_text("\rZ: 1\r\n");
          default: push_text({"Content-Length: ", $sformatf("%0d", $urandom_range(0, 30)),
                              "\r\n"});
        endcase
      end
    end
    // Size the body around the declared length so it ends short, exact or long.
    if (numeric && val <= 40) begin
      blen = int'(val) + int'($urandom_range(0, 4)) - 2;
      if (blen < 0) blen = 0;
    end else begin
      blen = $urandom_range(0, 12);
    end
    // Drop the header end now and then so the next request breaks in.
    if ($urandom_range(0, 9) != 0) begin
      push_text("\r\n");
      for (int i = 0; i < blen; i++) begin
        if ($urandom_range(0, 4) == 0) push_text(pick_chars(BODY_POOL, 1));
        else push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
  endtask

  // Hold until every byte is taken and every verdict has arrived, then let it settle.
  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || req.valid || verdict_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_max_body(input logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(REG_MAX_BODY));
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    max_body = v;
  endtask

  // Sender: bursts of random length with random gaps, some long bursts with no gap.
  initial begin : req_drive
    int    burst_left;
    int    gap_left;
    stim_t nxt;
    burst_left = 0;
    gap_left = 0;
    req.valid = 1'b0;
    req.data_byte = '0;
    req.starts_request = 1'b0;
    cur_item = '0;
    forever begin
      @(posedge clk);
      if (rst) begin
        req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
        if (gap_left != 0 || byte_q.size() == 0) begin
          req.valid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end else begin
          nxt = byte_q.pop_front();
          req.valid <= 1'b1;
          req.data_byte <= nxt.b;
          req.starts_request <= nxt.st;
          cur_item <= nxt;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                                      : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: switch between always ready, random stalls, a fixed beat and heavy stalls.
  initial begin : res_drive
    int         mode_left;
    int         stall_mode;
    logic [3:0] beat;
    mode_left = 0;
    stall_mode = 0;
    beat = '0;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 160);
      end else begin
        mode_left--;
      end
      beat++;
      case (stall_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= ($urandom_range(0, 3) != 0);
        2: res.ready <= (beat[1:0] != 2'b00) && (beat[3:2] != 2'b10);
        default: res.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Check each result against the oldest verdict, then predict for the byte taken now.
  // A result is registered behind the queue, so it never belongs to this edge's byte.
  always @(posedge clk) begin : check_proc
    verdict_t want;
    verdict_t got;
    if (!rst) begin
      if (res.valid && res.ready) begin
        got.complete = res.complete;
        got.status = res.status;
        got.content_length = res.content_length;
        if (verdict_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result %0d with nothing pending: complete=%0b status=%0d length=%0d",
                     result_idx, got.complete, got.status, got.content_length);
        end else begin
          want = verdict_q.pop_front();
          if (got.complete !== want.complete || got.status !== want.status ||
              got.content_length !== want.content_length) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"result %0d: expected complete=%0b status=%0d length=%0d,",
                        " got complete=%0b status=%0d length=%0d"},
                       result_idx, want.complete, want.status, want.content_length,
                       got.complete, got.status, got.content_length);
          end
        end
        result_idx++;
      end
      if (req.valid && req.ready) begin
        want = track_byte(req.data_byte, req.starts_request);
        // Hand-typed rows override the prediction; the state still advances.
        if (cur_item.lit) want = cur_item.want;
        verdict_q.push_back(want);
      end
    end
  end

  initial begin : main_seq
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    // Settings after the reset value: extremes first, then small limits, a random one,
    // and back to the reset value.
    cfg_vals[0] = 32'd0;
    cfg_vals[1] = 32'hFFFF_FFFF;
    cfg_vals[2] = 32'd1;
    cfg_vals[3] = 32'd9;
    cfg_vals[4] = 32'd10;
    cfg_vals[5] = 32'd100;
    cfg_vals[6] = $urandom;
    cfg_vals[7] = MAX_BODY_RESET;
    phase_items = 0;

    // Directed table. Reset state, then extreme bytes with no request start.
    push_item(8'h00, 1'b0, 1'b1, verdict_t'{1'b0, ST_OK, 32'd0});
    push_item(8'hFF, 1'b0, 1'b1, verdict_t'{1'b0, ST_OK, 32'd0});
    // Header ends with no tag: length zero, no body, so complete right away.
    push_text("\r\n\r");
    push_item(CHAR_LF, 1'b0, 1'b1, verdict_t'{1'b1, ST_OK, 32'd0});
    // Body byte with no length, and the error holds on the next byte.
    push_item(8'h41, 1'b0, 1'b1, verdict_t'{1'b0, ST_NO_LEN, 32'd0});
    push_item(8'hFF, 1'b0, 1'b1, verdict_t'{1'b0, ST_NO_LEN, 32'd0});
    // New request: tag found but no digit before the header ends.
    push_byte(CHAR_C, 1'b1);
    push_text("ontent-Length: \r\n\r");
    push_item(CHAR_LF, 1'b0, 1'b1, verdict_t'{1'b0, ST_BAD_LEN, 32'd0});

    // Random requests at the reset limit.
    while (phase_items < ITEMS_PER_PHASE) build_request();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Step through the settings, writing the register only while idle.
    for (int c = 0; c < NUM_CFG; c++) begin
      wait_idle();
      write_max_body(cfg_vals[c]);
      @(negedge clk);
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) build_request();
    end

    wait_idle();
    if (verdict_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #1_500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
